[rtl/mailbox_barrier_unit_defines.svh]
// Assertion macros for the mailbox barrier unit.
`ifndef MAILBOX_BARRIER_UNIT_DEFINES_SVH
`define MAILBOX_BARRIER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MBU_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mailbox barrier assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define MBU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mailbox barrier assertion failed");

`endif

[rtl/mbu_pkg.sv]
// Types and constants shared by the mailbox barrier unit modules.
package mbu_pkg;

   localparam int THREAD_W = 5;
   localparam int ADDR_W   = 32;

   localparam logic [ADDR_W-1:0] ADDR_LOW_MASK = 32'h000F_FFFF;

   localparam logic [1:0] KIND_REGISTERED = 2'd0;
   localparam logic [1:0] KIND_ERROR      = 2'd1;
   localparam logic [1:0] KIND_RELEASED   = 2'd2;
   localparam logic [1:0] KIND_SIGNAL     = 2'd3;

   typedef struct packed {
      logic [ADDR_W-1:0] mailbox_addr;
      logic              mailbox_busy;
   } req_type;

   typedef struct packed {
      logic [1:0]        result_kind;
      logic [ADDR_W-1:0] signal_addr;
      logic              last_of_run;
   } rsp_type;

   typedef struct packed {
      logic write;
      logic shift;
   } cell_ctrl_type;

endpackage

[rtl/mbu_cell.sv]
// One waiter-address cell: loads on write, takes its neighbor's word on shift.
module mbu_cell
   import mbu_pkg::*;
(
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [ADDR_W-1:0] write_data,
   input  logic [ADDR_W-1:0] next_data,
   output logic [ADDR_W-1:0] data
);

   logic [ADDR_W-1:0] data_ff;
   logic [ADDR_W-1:0] data_in;

   always_comb begin
      priority if (ctrl.write) begin
         data_in = write_data;
      end else if (ctrl.shift) begin
         data_in = next_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

[rtl/mbu_chain.sv]
// Row of address cells; drains toward cell 0 in arrival order.
module mbu_chain
   import mbu_pkg::*;
#(
   parameter int MAX_THREADS = 16
)(
   input  logic                           clock,
   input  logic                           write_en,
   input  logic [$clog2(MAX_THREADS)-1:0] write_index,
   input  logic [ADDR_W-1:0]              write_data,
   input  logic                           shift_en,
   output logic [ADDR_W-1:0]              head_data
);

   localparam int CW = $clog2(MAX_THREADS);

   logic [ADDR_W-1:0] cell_data [MAX_THREADS];

   for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
      cell_ctrl_type     ctrl;
      logic [ADDR_W-1:0] next_data;

      assign ctrl.write = write_en && (write_index == CW'(i));
      assign ctrl.shift = shift_en;

      if (i == MAX_THREADS - 1) begin : g_tail
         assign next_data = cell_data[i];
      end else begin : g_mid
         assign next_data = cell_data[i+1];
      end

      mbu_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .write_data (write_data),
         .next_data  (next_data),
         .data       (cell_data[i])
      );
   end

   assign head_data = cell_data[0];

endmodule

[rtl/mailbox_barrier_unit.sv]
// Registered, error and single-step release results appear in the cycle after accept; busy stays low.
// A last arrival with N stored waiters holds busy while it gives N signal results, one per
// cycle as the cell row shifts toward its head, then the release.
// Idle throughput is one arrival per cycle; no arrival is accepted while a release drains.
// Synchronous reset clears the arrival count and sets thread_count to 1; cells are not cleared.
module mailbox_barrier_unit
   import mbu_pkg::*;
#(
   parameter int MAX_THREADS = 16
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req,
   output logic                rsp_strobe,
   output rsp_type             rsp,
   input  logic                csr_write_enable,
   input  logic [THREAD_W-1:0] csr_write_data
);

`include "mailbox_barrier_unit_defines.svh"

   localparam int CW = $clog2(MAX_THREADS);
   localparam int EW = (CW + 1 > THREAD_W) ? CW + 1 : THREAD_W;

   localparam logic STATE_IDLE  = 1'b0;
   localparam logic STATE_DRAIN = 1'b1;

   logic                state_ff, state_in;
   logic [THREAD_W-1:0] thread_count_ff, thread_count_in;
   logic [CW-1:0]       arrival_count_ff, arrival_count_in;
   logic [CW-1:0]       drain_count_ff, drain_count_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   rsp_type             rsp_ff, rsp_in;

   logic          accept;
   logic          invalid;
   logic          is_last;
   logic [EW-1:0] threads_ext;
   logic [EW-1:0] threads_eff;
   logic [EW-1:0] count_next;
   logic          chain_write;
   logic          chain_shift;
   logic [ADDR_W-1:0] head_data;

   assign accept  = start && (state_ff == STATE_IDLE);
   assign invalid = req.mailbox_busy || ((req.mailbox_addr & ADDR_LOW_MASK) == '0);

   always_comb begin
      threads_ext = {{(EW-THREAD_W){1'b0}}, thread_count_ff};
      priority if (threads_ext == '0) begin
         threads_eff = EW'(1);
      end else if (threads_ext > EW'(MAX_THREADS)) begin
         threads_eff = EW'(MAX_THREADS);
      end else begin
         threads_eff = threads_ext;
      end
   end

   assign count_next = {{(EW-CW){1'b0}}, arrival_count_ff} + EW'(1);
   assign is_last    = count_next >= threads_eff;

   always_comb begin
      state_in         = state_ff;
      arrival_count_in = arrival_count_ff;
      drain_count_in   = drain_count_ff;
      rsp_strobe_in    = 1'b0;
      rsp_in           = '0;
      chain_write      = 1'b0;
      chain_shift      = 1'b0;

      unique case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               rsp_strobe_in      = 1'b1;
               rsp_in.last_of_run = 1'b1;
               priority if (invalid) begin
                  rsp_in.result_kind = KIND_ERROR;
               end else if (is_last) begin
                  arrival_count_in = '0;
                  if (arrival_count_ff == '0) begin
                     rsp_in.result_kind = KIND_RELEASED;
                  end else begin
                     // signals first; the release comes out at the end of the drain
                     rsp_strobe_in  = 1'b0;
                     drain_count_in = arrival_count_ff;
                     state_in       = STATE_DRAIN;
                  end
               end else begin
                  rsp_in.result_kind = KIND_REGISTERED;
                  chain_write        = 1'b1;
                  arrival_count_in   = arrival_count_ff + CW'(1);
               end
            end
         end
         STATE_DRAIN: begin
            rsp_strobe_in = 1'b1;
            if (drain_count_ff != '0) begin
               rsp_in.result_kind = KIND_SIGNAL;
               rsp_in.signal_addr = head_data;
               chain_shift        = 1'b1;
               drain_count_in     = drain_count_ff - CW'(1);
            end else begin
               rsp_in.result_kind = KIND_RELEASED;
               rsp_in.last_of_run = 1'b1;
               state_in           = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   assign thread_count_in = csr_write_enable ? csr_write_data : thread_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= STATE_IDLE;
         thread_count_ff  <= THREAD_W'(1);
         arrival_count_ff <= '0;
         drain_count_ff   <= '0;
         rsp_strobe_ff    <= 1'b0;
      end else begin
         state_ff         <= state_in;
         thread_count_ff  <= thread_count_in;
         arrival_count_ff <= arrival_count_in;
         drain_count_ff   <= drain_count_in;
         rsp_strobe_ff    <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   mbu_chain #(
      .MAX_THREADS (MAX_THREADS)
   ) u_chain (
      .clock       (clock),
      .write_en    (chain_write),
      .write_index (arrival_count_ff),
      .write_data  (req.mailbox_addr),
      .shift_en    (chain_shift),
      .head_data   (head_data)
   );

   assign busy       = (state_ff == STATE_DRAIN);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   `MBU_ASSERT_SAME(a_drain_count_clear, busy, arrival_count_ff == '0)
   `MBU_ASSERT_NEXT(a_accept_answers, start && !busy && !invalid && !is_last, rsp_strobe)
   `MBU_ASSERT_SAME(a_last_marks_end, rsp_strobe, rsp.last_of_run == (rsp.result_kind != KIND_SIGNAL))
   `MBU_ASSERT_SAME(a_count_in_range, 1'b1, EW'(arrival_count_ff) < EW'(MAX_THREADS))

endmodule
